/* design/dsd_pkg.sv */
// Shared types, constants and calendar helpers for the date shifter.
// No dependencies; every other design file imports this package.
package dsd_pkg;

    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int COUNT_BITS = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = YEAR_W;

    // Day accumulator: holds day_in + count or day_in - count, signed
    localparam int DAY_ACC_W  = COUNT_BITS + 2;
    // Walking year: signed, one bit above the field to see underflow
    localparam int YACC_W     = YEAR_W + 1;
    // Year modulo the 400-year cycle
    localparam int REM_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = YEAR_W'(1601);
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = YEAR_W'(9999);

    localparam logic [MON_W-1:0] JAN = MON_W'(1);
    localparam logic [MON_W-1:0] FEB = MON_W'(2);
    localparam logic [MON_W-1:0] DEC = MON_W'(12);

    localparam logic [DAY_W-1:0] LEAP_FEB_DAYS = DAY_W'(29);
    localparam int               CENTURY       = 100;
    localparam int               LEAP_CYCLE    = 400;
    localparam logic [REM_W-1:0] REM_LAST      = REM_W'(LEAP_CYCLE - 1);

    // year mod 400 by restoring subtraction of 400*2^k, k from high to low
    localparam int REDUCE_STEPS = 6;
    localparam int STEP_W       = 3;

    // Month lengths, non-leap; codes outside 1..12 read as zero
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    typedef struct packed {
        logic                  kind;
        logic [DAY_W-1:0]      day_in;
        logic [MON_W-1:0]      month_in;
        logic [YEAR_W-1:0]     year_in;
        logic [COUNT_BITS-1:0] day_count;
    } t_in_item;

    typedef struct packed {
        logic [DAY_W-1:0]  day_out;
        logic [MON_W-1:0]  month_out;
        logic [YEAR_W-1:0] year_out;
        logic              input_valid;
        logic              out_of_range;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic              load;
        logic              reduce;
        logic [STEP_W-1:0] step_idx;
        logic              check;
        logic              walk;
        logic              finish;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic start_ok;
        logic walk_done;
    } t_dp_sts;

    function automatic logic is_leap_rem(input logic [REM_W-1:0] rem);
        return (rem[1:0] == 2'b00)
            && (rem != REM_W'(CENTURY))
            && (rem != REM_W'(2 * CENTURY))
            && (rem != REM_W'(3 * CENTURY));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        return (m == FEB && leap) ? LEAP_FEB_DAYS : MONTH_LEN[m];
    endfunction

    function automatic logic [YEAR_W-1:0] reduce_sub(input logic [STEP_W-1:0] idx);
        logic [STEP_W-1:0] sh;
        sh = STEP_W'(REDUCE_STEPS - 1) - idx;
        return YEAR_W'(LEAP_CYCLE) << sh;
    endfunction

endpackage

/* design/dsd_ctrl.sv */
// Sequencer for the date shifter: load, year reduction, check, month walk, finish.
// Depends on dsd_pkg; drives dsd_dpath through t_dp_cmd.
module dsd_ctrl
    import dsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.step_idx = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_step       = r_step + 1'b1;
                if (r_step == STEP_W'(REDUCE_STEPS - 1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.start_ok ? ST_WALK : ST_FINISH;
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

/* design/dsd_dpath.sv */
// Datapath of the date shifter: operand registers, year-mod-400 tracker,
// day accumulator and month walker, result register. Depends on dsd_pkg.
module dsd_dpath
    import dsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_item,
    input  logic [YEAR_W-1:0] i_min_year,
    input  logic [YEAR_W-1:0] i_max_year,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_done,
    output t_out_item         o_result
);

    logic                        r_kind;
    logic [DAY_W-1:0]            r_din;
    logic [MON_W-1:0]            r_min;
    logic [YEAR_W-1:0]           r_yin;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        r_valid;
    logic signed [DAY_ACC_W-1:0] r_d;
    logic [MON_W-1:0]            r_m;
    logic signed [YACC_W-1:0]    r_y;
    logic [YEAR_W-1:0]           r_rem;
    t_out_item                   r_result;
    logic                        r_done;

    logic [REM_W-1:0] rem_cur;
    logic [DAY_W-1:0] dim_cur;
    logic [MON_W-1:0] prev_m;
    logic [REM_W-1:0] prev_rem;
    logic [REM_W-1:0] next_rem;
    logic             wrap_back;
    logic [DAY_W-1:0] dim_prev;
    logic [YEAR_W-1:0] rsub;
    logic             oor;
    logic [YEAR_W-1:0] y_mag;

    assign rem_cur   = r_rem[REM_W-1:0];
    assign dim_cur   = month_days(r_m, is_leap_rem(rem_cur));
    assign wrap_back = (r_m == JAN);
    assign prev_m    = wrap_back ? DEC : (r_m - 1'b1);
    assign prev_rem  = !wrap_back ? rem_cur
                     : ((rem_cur == '0) ? REM_LAST : (rem_cur - 1'b1));
    assign next_rem  = (rem_cur == REM_LAST) ? '0 : (rem_cur + 1'b1);
    assign dim_prev  = month_days(prev_m, is_leap_rem(prev_rem));
    assign rsub      = reduce_sub(i_cmd.step_idx);

    // start-date check; r_m still holds month_in, r_rem holds year mod 400
    assign o_sts.start_ok = (r_yin >= i_min_year)
                         && (r_min != '0) && (r_min <= DEC)
                         && (r_din != '0) && (r_din <= dim_cur);

    assign o_sts.walk_done = r_kind ? (r_d > 0)
                                    : (r_d <= $signed(DAY_ACC_W'(dim_cur)));

    assign y_mag = r_y[YEAR_W-1:0];
    assign oor   = r_valid && (r_y[YACC_W-1] || (y_mag < i_min_year)
                                             || (y_mag > i_max_year));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_din  <= i_item.day_in;
            r_min  <= i_item.month_in;
            r_yin  <= i_item.year_in;
            r_cnt  <= i_item.day_count[COUNT_BITS-1:0];
            r_m    <= i_item.month_in;
            r_y    <= $signed(YACC_W'(i_item.year_in));
            r_rem  <= i_item.year_in;
        end
        if (i_cmd.reduce && (r_rem >= rsub)) begin
            r_rem <= r_rem - rsub;
        end
        if (i_cmd.check) begin
            r_valid <= o_sts.start_ok;
            if (r_kind) begin
                r_d <= $signed(DAY_ACC_W'(r_din) - DAY_ACC_W'(r_cnt));
            end else begin
                r_d <= $signed(DAY_ACC_W'(r_din) + DAY_ACC_W'(r_cnt));
            end
        end
        if (i_cmd.walk) begin
            if (r_kind) begin
                // borrow: step back a month, add that month's length
                r_m   <= prev_m;
                r_rem <= YEAR_W'(prev_rem);
                r_d   <= r_d + $signed(DAY_ACC_W'(dim_prev));
                if (wrap_back) begin
                    r_y <= r_y - 1'b1;
                end
            end else begin
                r_d <= r_d - $signed(DAY_ACC_W'(dim_cur));
                if (r_m == DEC) begin
                    r_m   <= JAN;
                    r_y   <= r_y + 1'b1;
                    r_rem <= YEAR_W'(next_rem);
                end else begin
                    r_m <= r_m + 1'b1;
                end
            end
        end
        if (i_cmd.finish) begin
            r_result.input_valid  <= r_valid;
            r_result.out_of_range <= oor;
            if (!r_valid || oor) begin
                r_result.day_out   <= r_din;
                r_result.month_out <= r_min;
                r_result.year_out  <= r_yin;
            end else begin
                r_result.day_out   <= r_d[DAY_W-1:0];
                r_result.month_out <= r_m;
                r_result.year_out  <= y_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* design/date_shift_by_days.sv */
// Top level of the date shifter: configuration registers, sequencer and datapath.
// Depends on dsd_pkg, dsd_ctrl and dsd_dpath.
//
// Adds a day count to, or subtracts it from, a Gregorian day/month/year date.
// Issue a beat by holding start high while busy is low; the item fields are
// sampled at that edge. The result beat appears on o_result for exactly one
// cycle with o_done high and cannot be held off, so capture it then. busy is
// already low in the o_done cycle, so the next start may land there. A beat
// runs through these steps: reduce the start year modulo 400 for the leap test,
// a check state, the month walk (skipped for an invalid start date), which
// steps one month per cycle and ends with a final compare, and a finish state.
// The user must write min_year and max_year through i_cfg_* only while idle;
// the block does not enforce this. They reset to 1601 and 9999. An invalid start
// echoes the input date with input_valid low; a result year outside
// [min_year, max_year] echoes the input date with out_of_range high.
module date_shift_by_days
    import dsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_done,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // Year limits; the user must keep config still while a beat is in flight, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                CFG_MAX_YEAR: r_max_year <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    dsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    dsd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // accepted beat always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // result strobe is a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // range flag only on a valid start
    a_oor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_of_range) |-> o_result.input_valid)
        else $error("out_of_range set on invalid start");

    // a shifted result is a real calendar date
    a_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.input_valid && !o_result.out_of_range) |->
        ((o_result.month_out != '0) && (o_result.month_out <= DEC)
         && (o_result.day_out != '0)))
        else $error("shifted date outside calendar");

endmodule
